/* rtl/csdq_pkg.sv */
package csdq_pkg;

    // Field widths of the external channels.
    localparam int AngleW = 32;
    localparam int TrigW  = 18;

    // Internal widths. A reduced angle lies within +-90 degrees, so 24 signed bits hold it.
    // The accumulated angle stays below the sum of the arctangent table.
    // The rotating vector stays near 65540 in magnitude.
    localparam int DegW  = 24;
    localparam int AccW  = 24;
    localparam int XyW   = 20;
    localparam int TurnW = 26;

    // CORDIC step count.
    localparam int StepsMax     = 16;
    localparam int StepsDefault = 16;

    // Depth of the queue between the reduction front end and the rotation pipeline.
    localparam int QueueDepth = 4;

    // Angle constants in Q16.16 degrees.
    localparam logic signed [TurnW-1:0] HalfTurn    = 26'sd11796480;
    localparam logic signed [TurnW-1:0] FullTurn    = 26'sd23592960;
    localparam logic signed [TurnW-1:0] QuarterTurn = 26'sd5898240;

    // Whole degrees modulo 360. The 16 bit integer degree count is offset by 32768
    // to make it unsigned. Because 32768 mod 360 is 8, adding 352 keeps the residue.
    localparam int TurnDegrees  = 360;
    localparam int ModOffset    = 352;
    localparam int RecipShift   = 24;
    localparam int RecipMod360  = (1 << RecipShift) / TurnDegrees;

    // Prescaled start value of the x component.
    localparam logic signed [XyW-1:0] StartX = 20'sd39796;

    // Arctangent step table in Q16.16 degrees.
    localparam logic signed [AccW-1:0] AtanTable [StepsMax] = '{
        24'sd2949120, 24'sd1740963, 24'sd919876, 24'sd466945,
        24'sd234378,  24'sd117303,  24'sd58666,  24'sd29334,
        24'sd14667,   24'sd7333,    24'sd3666,   24'sd1833,
        24'sd458,     24'sd229,     24'sd114,    24'sd57
    };

    // One reduced angle on its way from the front end to the rotation pipeline.
    typedef struct packed {
        logic signed [DegW-1:0] deg;
        logic                   fold;
    } t_item;

endpackage

/* rtl/csdq_front.sv */
module csdq_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [csdq_pkg::AngleW-1:0]    i_angle,
    output logic                                  o_push,
    input  logic                                  i_full,
    output csdq_pkg::t_item                       o_item
);
    import csdq_pkg::*;

    logic                     en;
    logic [16:0]              w_mod_in;
    logic [32:0]              w_prod;

    logic                     r_v1;
    logic [15:0]              r_low1;
    logic [16:0]              r_mod_in1;
    logic [31:0]              r_prod1;

    logic [7:0]               w_quot;
    logic [16:0]              w_q360;
    logic [16:0]              w_rem;
    logic [9:0]               w_rem10;
    logic [8:0]               w_whole;
    logic signed [TurnW-1:0]  w_red;
    logic signed [TurnW-1:0]  w_wrap;
    logic signed [TurnW-1:0]  w_fold_deg;
    logic                     w_fold;

    logic                     r_v2;
    t_item                    r_item;

    // The whole front end advances together whenever its last stage can hand off.
    assign en      = !r_v2 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v2 && !i_full;
    assign o_item  = r_item;

    // Offset the whole degree count to an unsigned value with the same residue mod 360.
    assign w_mod_in = {1'b0, ~i_angle[31], i_angle[30:16]} + 17'(ModOffset);
    assign w_prod   = {16'd0, w_mod_in} * 33'(RecipMod360);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_low1    <= i_angle[15:0];
            r_mod_in1 <= w_mod_in;
            r_prod1   <= w_prod[31:0];
        end
    end

    // The reciprocal estimate is the true quotient or one less, so one correction step suffices.
    always_comb begin
        w_quot  = r_prod1[31:24];
        w_q360  = 17'(w_quot) * 17'(TurnDegrees);
        w_rem   = r_mod_in1 - w_q360;
        w_rem10 = w_rem[9:0];
        if (w_rem10 >= 10'(TurnDegrees)) begin
            w_whole = 9'(w_rem10 - 10'(TurnDegrees));
        end else begin
            w_whole = w_rem10[8:0];
        end
        w_red = {1'b0, w_whole, r_low1};
        if (w_red > HalfTurn) begin
            w_wrap = w_red - FullTurn;
        end else begin
            w_wrap = w_red;
        end
        if (w_wrap > QuarterTurn) begin
            w_fold_deg = HalfTurn - w_wrap;
            w_fold     = 1'b1;
        end else if (w_wrap < -QuarterTurn) begin
            w_fold_deg = -HalfTurn - w_wrap;
            w_fold     = 1'b1;
        end else begin
            w_fold_deg = w_wrap;
            w_fold     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item.deg  <= w_fold_deg[DegW-1:0];
            r_item.fold <= w_fold;
        end
    end

endmodule

/* rtl/csdq_queue.sv */
module csdq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csdq_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output csdq_pkg::t_item o_item
);
    import csdq_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    t_item            r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/csdq_back.sv */
module csdq_back #(
    parameter int STEPS = csdq_pkg::StepsDefault
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_pop,
    input  csdq_pkg::t_item                      i_item,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [csdq_pkg::TrigW-1:0]    o_sine,
    output logic signed [csdq_pkg::TrigW-1:0]    o_cosine
);
    import csdq_pkg::*;

    logic                     en;

    logic                     r_v    [STEPS];
    logic signed [XyW-1:0]    r_x    [STEPS];
    logic signed [XyW-1:0]    r_y    [STEPS];
    logic signed [AccW-1:0]   r_acc  [STEPS];
    logic signed [DegW-1:0]   r_deg  [STEPS];
    logic                     r_fold [STEPS];

    logic signed [XyW-1:0]    w_x_out;
    logic                     r_out_v;
    logic signed [TrigW-1:0]  r_sine;
    logic signed [TrigW-1:0]  r_cosine;

    // The pipeline moves as one unit unless the output register holds an untaken result.
    assign en       = !r_out_v || i_ready;
    assign o_pop    = en && i_valid;
    assign o_valid  = r_out_v;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic                   v_in;
        logic signed [XyW-1:0]  x_in;
        logic signed [XyW-1:0]  y_in;
        logic signed [AccW-1:0] acc_in;
        logic signed [DegW-1:0] deg_in;
        logic                   fold_in;
        logic signed [XyW-1:0]  n_x;
        logic signed [XyW-1:0]  n_y;
        logic signed [AccW-1:0] n_acc;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = StartX;
            assign y_in    = '0;
            assign acc_in  = '0;
            assign deg_in  = i_item.deg;
            assign fold_in = i_item.fold;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign x_in    = r_x[g-1];
            assign y_in    = r_y[g-1];
            assign acc_in  = r_acc[g-1];
            assign deg_in  = r_deg[g-1];
            assign fold_in = r_fold[g-1];
        end

        // Equal residual and accumulated angle rotates in the negative direction.
        always_comb begin
            if (deg_in > acc_in) begin
                n_x   = x_in - (y_in >>> g);
                n_y   = y_in + (x_in >>> g);
                n_acc = acc_in + AtanTable[g];
            end else begin
                n_x   = x_in + (y_in >>> g);
                n_y   = y_in - (x_in >>> g);
                n_acc = acc_in - AtanTable[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_acc[g]  <= n_acc;
                r_deg[g]  <= deg_in;
                r_fold[g] <= fold_in;
            end
        end
    end

    assign w_x_out = r_fold[STEPS-1] ? -r_x[STEPS-1] : r_x[STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sine   <= r_y[STEPS-1][TrigW-1:0];
            r_cosine <= w_x_out[TrigW-1:0];
        end
    end

endmodule

/* rtl/cordic_sin_cos_degrees_q16.sv */
// Sine and cosine of an angle given in degrees, CORDIC in rotation mode.
// The input channel (i_valid, o_ready, i_angle) takes one signed Q16.16 angle
// per request, where 65536 stands for one degree. Every request yields exactly
// one result on the output channel (o_valid, i_ready, o_sine, o_cosine), both
// in signed Q2.16 with 65536 standing for 1.0, in the order the angles came.
// A front end folds the angle into +-90 degrees over two register stages,
// then a four-entry queue hands it to a rotation pipeline of STEPS stages
// followed by an output register. Throughput is one request per cycle while
// the receiver keeps i_ready high; each CORDIC step is its own stage, so
// the step count sets latency only.
// When the receiver holds i_ready low, the result stays on the outputs and the
// rotation pipeline stops. The queue keeps absorbing front-end results until
// it fills, and only then does o_ready fall.
// Reset is synchronous and active low. It empties every stage and the queue.
// There is no other state, so no warm-up pass follows reset.
module cordic_sin_cos_degrees_q16 #(
    parameter int STEPS = csdq_pkg::StepsDefault
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [csdq_pkg::AngleW-1:0]   i_angle,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [csdq_pkg::TrigW-1:0]    o_sine,
    output logic signed [csdq_pkg::TrigW-1:0]    o_cosine
);
    import csdq_pkg::*;

    // Front end to queue.
    logic   w_push;
    logic   w_full;
    t_item  w_front_item;

    // Queue to rotation pipeline.
    logic   w_q_valid;
    logic   w_pop;
    t_item  w_q_item;

    // Turn reduction and the fold into +-90 degrees. The fold flag rides along
    // with the angle so that the rotation pipeline can negate the cosine at its end.
    csdq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_angle (i_angle),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_item  (w_front_item)
    );

    // The queue lets the front end keep accepting while the output is stalled.
    csdq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // One micro-rotation per stage, then the output register.
    csdq_back #(
        .STEPS (STEPS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_pop    (w_pop),
        .i_item   (w_q_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

endmodule

/* rtl/csdq_checker.sv */
module csdq_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic signed [csdq_pkg::AngleW-1:0]   i_angle,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic signed [csdq_pkg::TrigW-1:0]    o_sine,
    input  logic signed [csdq_pkg::TrigW-1:0]    o_cosine
);
    import csdq_pkg::*;

    localparam int CntW = 8;
    localparam logic signed [TrigW-1:0] TrigLimit = 18'sd66000;

    logic [CntW-1:0] r_open;
    logic            w_in_acc;
    logic            w_out_acc;

    assign w_in_acc  = i_valid && o_ready && (i_angle == i_angle);
    assign w_out_acc = o_valid && i_ready;

    // Requests accepted but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_open <= r_open + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_open <= r_open - 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sine) && $stable(o_cosine))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_open != '0)
        else $error("result presented with no open request");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine <= TrigLimit) && (o_sine >= -TrigLimit))
        else $error("sine out of range");

    a_cosine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cosine <= TrigLimit) && (o_cosine >= -TrigLimit))
        else $error("cosine out of range");

endmodule

bind cordic_sin_cos_degrees_q16 csdq_checker u_csdq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_angle  (i_angle),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_sine   (o_sine),
    .o_cosine (o_cosine)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

// Checks the CORDIC sine/cosine block against a cycle-free predictor.
// The sender offers signed Q16.16 degree angles and the receiver takes results.
// Both sides stall at random, and each accepted request queues one expected
// result that is checked in order against the outputs.
module testbench;

    import csdq_pkg::*;

    // Q16.16 degree units used by the predictor and by the stimulus.
    localparam longint Deg         = 65536;
    localparam longint HalfTurnQ   = 180 * Deg;
    localparam longint FullTurnQ   = 360 * Deg;
    localparam longint QuarterQ    = 90 * Deg;
    localparam longint StartXQ     = 39796;
    localparam int     CordicSteps = StepsDefault;

    localparam int SettleCycles  = 2 * (CordicSteps + 3);
    localparam int HoldOffCycles = 200;
    localparam int DirectedCount = 25;

    typedef struct packed {
        logic signed [TrigW-1:0] sine;
        logic signed [TrigW-1:0] cosine;
    } t_trig_pair;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [AngleW-1:0] i_angle;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [TrigW-1:0]  o_sine;
    logic signed [TrigW-1:0]  o_cosine;

    // Results still owed by the block, oldest first.
    t_trig_pair pending_results [$];
    int unsigned mismatch_count = 0;

    // Chance in percent that the sender inserts a gap before a request, and
    // that the receiver drops ready in a given cycle.
    int unsigned gap_pct   = 12;
    int unsigned stall_pct = 12;
    bit          hold_pending = 1'b0;

    cordic_sin_cos_degrees_q16 #(
        .STEPS(CordicSteps)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_angle (i_angle),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_sine  (o_sine),
        .o_cosine(o_cosine)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Arctangent of 2^-s in Q16.16 degrees. The tail entries are kept exactly
    // as the block uses them, even though they are not true arctangents.
    function automatic longint arctan_q16(int s);
        case (s)
            0:       return 2949120;
            1:       return 1740963;
            2:       return 919876;
            3:       return 466945;
            4:       return 234378;
            5:       return 117303;
            6:       return 58666;
            7:       return 29334;
            8:       return 14667;
            9:       return 7333;
            10:      return 3666;
            11:      return 1833;
            12:      return 458;
            13:      return 229;
            14:      return 114;
            default: return 57;
        endcase
    endfunction

    // Predicts the result for one angle: turn reduction, fold into +-90
    // degrees, then the CORDIC rotation from the prescaled start vector.
    function automatic t_trig_pair predict_sin_cos(logic signed [AngleW-1:0] angle);
        longint     deg;
        longint     turns;
        longint     x;
        longint     y;
        longint     nx;
        longint     acc;
        bit         folded;
        t_trig_pair res;
        deg    = longint'(angle);
        x      = StartXQ;
        y      = 0;
        acc    = 0;
        folded = 1'b0;
        // Exactly +-180 degrees is left alone; anything beyond is pulled in by
        // the smallest number of whole turns.
        if (deg > HalfTurnQ) begin
            turns = (deg - HalfTurnQ + FullTurnQ - 1) / FullTurnQ;
            deg   = deg - turns * FullTurnQ;
        end else if (deg < -HalfTurnQ) begin
            turns = (-HalfTurnQ - deg + FullTurnQ - 1) / FullTurnQ;
            deg   = deg + turns * FullTurnQ;
        end
        if (deg > QuarterQ) begin
            deg    = HalfTurnQ - deg;
            folded = 1'b1;
        end else if (deg < -QuarterQ) begin
            deg    = -HalfTurnQ - deg;
            folded = 1'b1;
        end
        // A tie between residual and accumulated angle rotates negatively.
        for (int s = 0; s < CordicSteps; s++) begin
            if (deg > acc) begin
                nx  = x - (y >>> s);
                y   = y + (x >>> s);
                acc = acc + arctan_q16(s);
            end else begin
                nx  = x + (y >>> s);
                y   = y - (x >>> s);
                acc = acc - arctan_q16(s);
            end
            x = nx;
        end
        if (folded) begin
            x = -x;
        end
        res.sine   = y[TrigW-1:0];
        res.cosine = x[TrigW-1:0];
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Offers one angle and returns at the edge where it was accepted. The
    // caller always sits just after a rising edge, so every drive here is
    // the only one to its signal in that time step.
    task automatic send_angle(logic signed [AngleW-1:0] angle);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_angle <= angle;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_sin_cos(angle));
    endtask

    // Drops valid and waits until the block has delivered everything it owes.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Random angles, shaped toward the interesting parts of the range: the
    // fold and half-turn boundaries, exact quarter turns, large multiples of
    // a turn, tiny angles, and plain random words over the full 32 bits.
    function automatic logic signed [AngleW-1:0] random_angle();
        longint a;
        case ($urandom_range(9))
            0, 1, 2: a = longint'($signed($urandom));
            3, 4, 5: a = longint'($urandom_range(0, 800 * Deg)) - 400 * Deg;
            6, 7:    a = (longint'($urandom_range(0, 16)) - 8) * QuarterQ
                         + longint'($urandom_range(0, 8)) - 4;
            8:       a = (longint'($urandom_range(0, 180)) - 90) * FullTurnQ
                         + longint'($urandom_range(0, 400 * Deg)) - 200 * Deg;
            default: a = longint'($urandom_range(0, 4 * Deg)) - 2 * Deg;
        endcase
        return a[AngleW-1:0];
    endfunction

    // Directed angles: zero and the tie at the first step, the exact and
    // off-by-one edges of the fold and of the turn reduction, whole turns,
    // the extremes of the 32-bit field and alternating bit patterns. None of
    // the results can be read off by eye, so all rows use the predictor.
    logic signed [AngleW-1:0] directed_angles [DirectedCount] = '{
        32'sd0,              32'sd1,              -32'sd1,
        32'sd2949120,        32'sd5898240,        -32'sd5898240,
        32'sd5898241,        -32'sd5898241,       32'sd11796480,
        -32'sd11796480,      32'sd11796481,       -32'sd11796481,
        32'sd23592960,       -32'sd23592960,      32'sd17694720,
        -32'sd17694720,      32'sd35389440,       32'sh7FFF_FFFF,
        32'sh8000_0000,      32'sh5555_5555,      32'shAAAA_AAAA,
        32'sh0000_FFFF,      32'shFFFF_0000,      32'sd65536,
        -32'sd65536
    };

    // Receiver ready. Mostly random, with a long hold-off on request so the
    // pipeline and queue fill and the block pushes back on its input.
    initial begin : ready_gen
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Results are taken at the edge where valid and ready are both high.
    always @(posedge i_clk) begin : result_check
        t_trig_pair want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result sine=%0d cosine=%0d",
                                          o_sine, o_cosine));
            end else begin
                want = pending_results.pop_front();
                if (o_sine !== want.sine) begin
                    report_mismatch($sformatf("sine got %0d want %0d", o_sine, want.sine));
                end
                if (o_cosine !== want.cosine) begin
                    report_mismatch($sformatf("cosine got %0d want %0d",
                                              o_cosine, want.cosine));
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_angle = '0;
        i_ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_angles[i]) begin
            send_angle(directed_angles[i]);
        end
        // Let the block run dry before the random part starts.
        drain_results();

        for (int n = 0; n < 1400; n++) begin
            // A long stretch with no idling on either side.
            if (n == 400) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (n == 600) begin
                gap_pct   = 12;
                stall_pct = 12;
            end
            // Receiver holds off while the sender keeps requests coming.
            if (n == 800) begin
                hold_pending = 1'b1;
            end
            send_angle(random_angle());
        end

        drain_results();
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
